>>> hdl/gclu_pkg.sv
// gclu_pkg: shared types and constants for the gcd / lcm unit
// no dependencies; imported by gclu_alu, gcd_lcm_unit and gcd_lcm_unit_tb
`default_nettype none

package gclu_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH       = 32;
    localparam int RESULT_WIDTH      = 64;

    localparam logic OP_GCD = 1'b0;
    localparam logic OP_LCM = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [FIELD_WIDTH-1:0] operand_a;
        logic [FIELD_WIDTH-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] result_value;
        logic                    undefined_flag;
    } t_out_item;

endpackage

`default_nettype wire

>>> hdl/gclu_alu.sv
// gclu_alu: shared add / subtract unit with carry out
// depends on gclu_pkg for the default width
`default_nettype none

module gclu_alu
    import gclu_pkg::*;
#(
    parameter int WIDTH = 2 * OPERAND_WIDTH_DEF
) (
    input  logic             i_sub,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);

    logic [WIDTH:0] w_sum;

    // carry set on subtract means no borrow
    assign w_sum   = {1'b0, i_a} + {1'b0, i_b ^ {WIDTH{i_sub}}} + {{WIDTH{1'b0}}, i_sub};
    assign o_sum   = w_sum[WIDTH-1:0];
    assign o_carry = w_sum[WIDTH];

endmodule

`default_nettype wire

>>> hdl/gcd_lcm_unit.sv
// Iterative gcd / lcm unit. One item is taken when start is high and busy is low; its
// single result appears on o_result for exactly one cycle with o_strobe high, and the
// receiver must take it then. An operand of zero gives its result in the next cycle. Otherwise the
// gcd is found by the binary method, one shift, swap or subtract per cycle through the
// shared adder; an lcm then adds a restoring division of operand_a by the gcd and a
// shift-add multiply of the quotient by operand_b, again on the same adder. Operand
// bits above OPERAND_WIDTH are ignored.
// depends on gclu_pkg and gclu_alu
`default_nettype none

module gcd_lcm_unit
    import gclu_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(OPERAND_WIDTH);
    localparam logic [KW-1:0] CNT_LAST = KW'(OPERAND_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL
    } t_state;

    t_state r_state, n_state;
    logic              r_op, n_op;
    logic [W-1:0]      r_a, n_a;
    logic [W-1:0]      r_b, n_b;
    logic [W-1:0]      r_x, n_x;
    logic [W-1:0]      r_y, n_y;
    logic [KW-1:0]     r_k, n_k;
    logic [W-1:0]      r_rem, n_rem;
    logic [W-1:0]      r_q, n_q;
    logic [DW-1:0]     r_acc, n_acc;
    logic [KW-1:0]     r_cnt, n_cnt;
    logic              r_strobe, n_strobe;
    t_out_item         r_result, n_result;

    logic              w_sub;
    logic [DW-1:0]     w_alu_a;
    logic [DW-1:0]     w_alu_b;
    logic [DW-1:0]     w_alu_sum;
    logic              w_alu_carry;
    logic [W-1:0]      w_in_a;
    logic [W-1:0]      w_in_b;
    logic [W-1:0]      w_gcd;
    logic [W:0]        w_rem_sh;

    gclu_alu #(
        .WIDTH (DW)
    ) u_alu (
        .i_sub   (w_sub),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_sum   (w_alu_sum),
        .o_carry (w_alu_carry)
    );

    assign w_in_a   = i_item.operand_a[W-1:0];
    assign w_in_b   = i_item.operand_b[W-1:0];
    assign w_gcd    = r_x << r_k;
    assign w_rem_sh = {r_rem, r_q[W-1]};

    // shared adder operand selection
    always_comb begin
        w_sub   = 1'b1;
        w_alu_a = DW'(r_x);
        w_alu_b = DW'(r_y);
        case (r_state)
            S_DIV: begin
                w_alu_a = DW'(w_rem_sh);
                w_alu_b = DW'(r_y);
            end
            S_MUL: begin
                w_sub   = 1'b0;
                w_alu_a = {r_acc[DW-2:0], 1'b0};
                w_alu_b = r_q[W-1] ? DW'(r_b) : '0;
            end
            default: begin
                w_sub   = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_a      = r_a;
        n_b      = r_b;
        n_x      = r_x;
        n_y      = r_y;
        n_k      = r_k;
        n_rem    = r_rem;
        n_q      = r_q;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_item.op;
                    n_a  = w_in_a;
                    n_b  = w_in_b;
                    n_x  = w_in_a;
                    n_y  = w_in_b;
                    n_k  = '0;
                    if (w_in_a == '0 || w_in_b == '0) begin
                        n_strobe                = 1'b1;
                        n_result.result_value   = (i_item.op == OP_GCD) ?
                                                  RESULT_WIDTH'(w_in_a | w_in_b) : '0;
                        n_result.undefined_flag = (i_item.op == OP_LCM) &&
                                                  (w_in_a == '0) && (w_in_b == '0);
                    end else begin
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (!w_alu_carry) begin
                    // keep the larger value in x
                    n_x = r_y;
                    n_y = r_x;
                end else if (w_alu_sum[W-1:0] == '0) begin
                    if (r_op == OP_GCD) begin
                        n_state                 = S_IDLE;
                        n_strobe                = 1'b1;
                        n_result.result_value   = RESULT_WIDTH'(w_gcd);
                        n_result.undefined_flag = 1'b0;
                    end else begin
                        n_state = S_DIV;
                        n_y     = w_gcd;
                        n_q     = r_a;
                        n_rem   = '0;
                        n_cnt   = CNT_LAST;
                    end
                end else begin
                    n_x = w_alu_sum[W-1:0];
                end
            end
            S_DIV: begin
                if (w_alu_carry) begin
                    n_rem = w_alu_sum[W-1:0];
                end else begin
                    n_rem = w_rem_sh[W-1:0];
                end
                n_q   = {r_q[W-2:0], w_alu_carry};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                    n_cnt   = CNT_LAST;
                    n_acc   = '0;
                end
            end
            S_MUL: begin
                n_acc = w_alu_sum;
                n_q   = {r_q[W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state                 = S_IDLE;
                    n_strobe                = 1'b1;
                    n_result.result_value   = RESULT_WIDTH'(w_alu_sum);
                    n_result.undefined_flag = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_x      <= n_x;
        r_y      <= n_y;
        r_k      <= n_k;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> tb/sv/gcd_lcm_unit_tb.sv
// gcd_lcm_unit_tb: self-checking testbench for the gcd / lcm unit
// holds a scoreboard class with its own gcd / lcm predictor; drives directed and random items
// depends on gclu_pkg and gcd_lcm_unit
`default_nettype none

module gcd_lcm_unit_tb;
    import gclu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPW           = OPERAND_WIDTH_DEF;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 950;
    localparam int PHASE_COUNT   = 4;

    class gcd_lcm_scoreboard;
        t_out_item expected_q[$];
        int        errors = 0;

        function automatic logic [RESULT_WIDTH-1:0] euclid_gcd(logic [RESULT_WIDTH-1:0] x,
                                                               logic [RESULT_WIDTH-1:0] y);
            while (x != 0 && y != 0) begin
                if (x > y) begin
                    x = x % y;
                end else begin
                    y = y % x;
                end
            end
            return x + y;
        endfunction

        function automatic t_out_item compute_gcd_lcm(t_in_item it);
            logic [RESULT_WIDTH-1:0] mask;
            logic [RESULT_WIDTH-1:0] a;
            logic [RESULT_WIDTH-1:0] b;
            logic [RESULT_WIDTH-1:0] g;
            t_out_item               res;
            mask = (RESULT_WIDTH'(1) << OPW) - 1;
            a = RESULT_WIDTH'(it.operand_a) & mask;
            b = RESULT_WIDTH'(it.operand_b) & mask;
            g = euclid_gcd(a, b);
            res.result_value   = '0;
            res.undefined_flag = 1'b0;
            if (it.op == OP_GCD) begin
                res.result_value = g;
            end else if (g == 0) begin
                res.undefined_flag = 1'b1;
            end else begin
                res.result_value = (a * b) / g;
            end
            return res;
        endfunction

        function void note_item(t_in_item it);
            expected_q.push_back(compute_gcd_lcm(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: result_value %0h, undefined_flag %0b",
                       got.result_value, got.undefined_flag);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.result_value !== want.result_value) begin
                $error("result_value: expected %0h, got %0h",
                       want.result_value, got.result_value);
                errors++;
            end
            if (got.undefined_flag !== want.undefined_flag) begin
                $error("undefined_flag: expected %0b, got %0b",
                       want.undefined_flag, got.undefined_flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    gcd_lcm_scoreboard sb = new();
    int                idle_pct = 0;
    int                quiet_cycles = 0;

    gcd_lcm_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    // result check first so a stray strobe never matches a freshly taken item
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_result);
        end
        if (i_rst_n && start && !busy) begin
            sb.note_item(i_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item make_item(logic op, logic [FIELD_WIDTH-1:0] a,
                                           logic [FIELD_WIDTH-1:0] b);
        t_in_item it;
        it.op        = op;
        it.operand_a = a;
        it.operand_b = b;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item               it;
        logic [FIELD_WIDTH-1:0] f;
        logic [FIELD_WIDTH-1:0] tmp;
        int                     kind;
        kind = $urandom_range(0, 9);
        it.op = 1'($urandom_range(0, 1));
        case (kind)
            0, 1, 2, 3: begin
                it.operand_a = $urandom;
                it.operand_b = $urandom;
            end
            4: begin
                it.operand_a = $urandom_range(0, 255);
                it.operand_b = $urandom_range(0, 255);
            end
            5, 6: begin
                // shared factor so the gcd is not trivially one
                f = $urandom_range(1, 65535);
                it.operand_a = f * $urandom_range(0, 65535);
                it.operand_b = f * $urandom_range(0, 65535);
            end
            7: begin
                it.operand_a = 32'd1 << $urandom_range(0, 31);
                it.operand_b = $urandom << $urandom_range(0, 31);
            end
            8: begin
                it.operand_a = $urandom_range(0, 1) ? '0 : '1;
                it.operand_b = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
            end
            default: begin
                it.operand_a = $urandom;
                it.operand_b = $urandom_range(0, 1) ? it.operand_a
                                                   : it.operand_a >> $urandom_range(0, 31);
            end
        endcase
        if ($urandom_range(0, 1)) begin
            tmp          = it.operand_a;
            it.operand_a = it.operand_b;
            it.operand_b = tmp;
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int phase_pcts[PHASE_COUNT];
        phase_pcts = '{0, 57, 0, 13};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_item(make_item(OP_GCD, 32'd0, 32'd0));
        send_item(make_item(OP_LCM, 32'd0, 32'd0));
        send_item(make_item(OP_GCD, 32'd0, 32'd12345));
        send_item(make_item(OP_GCD, 32'hFFFF_FFFF, 32'd0));
        send_item(make_item(OP_LCM, 32'd0, 32'hFFFF_FFFF));
        send_item(make_item(OP_LCM, 32'd77, 32'd0));
        send_item(make_item(OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
        send_item(make_item(OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
        send_item(make_item(OP_GCD, 32'd1, 32'hFFFF_FFFF));
        send_item(make_item(OP_LCM, 32'hFFFF_FFFF, 32'd1));
        send_item(make_item(OP_GCD, 32'h8000_0000, 32'h4000_0000));
        send_item(make_item(OP_LCM, 32'h8000_0000, 32'h8000_0000));
        send_item(make_item(OP_LCM, 32'hFFFF_FFFB, 32'hFFFF_FFEF));
        send_item(make_item(OP_GCD, 32'd1071, 32'd462));
        send_item(make_item(OP_LCM, 32'd462, 32'd1071));
        send_item(make_item(OP_GCD, 32'd1, 32'd1));
        send_item(make_item(OP_LCM, 32'd1, 32'd1));
        send_item(make_item(OP_GCD, 32'hAAAA_AAAA, 32'h5555_5555));
        send_item(make_item(OP_LCM, 32'hAAAA_AAAA, 32'h5555_5555));
        wait_for_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            idle_pct = phase_pcts[p];
            for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
                send_item(random_item());
            end
            // hold off until every outstanding result is back
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
